@@ hdl/url_alphabet_base64_decoder_assert.svh @@
// Assertion macros used by the serialiser module (uabd_back).
`ifndef URL_ALPHABET_BASE64_DECODER_ASSERT_SVH
`define URL_ALPHABET_BASE64_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define UABD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define UABD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define UABD_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`else
`define UABD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define UABD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define UABD_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

@@ hdl/uabd_pkg.sv @@
package uabd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_DASH = 8'h2d;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

   localparam logic [5:0] DIGIT_BASE = 6'd26;
   localparam logic [5:0] UPPER_BASE = 6'd36;
   localparam logic [5:0] DASH_VALUE = 6'd62;
   localparam logic [5:0] UNDERSCORE_VALUE = 6'd63;

   localparam logic [1:0] GROUP_FULL = 2'd3;

   typedef struct packed {
      logic       ok;
      logic [5:0] val;
   } sextet_type;

   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      last_idx;
      logic            has_byte;
      logic            message_end;
   } job_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      r.ok = 1'b1;
      r.val = '0;
      if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         r.val = 6'(c - CHAR_LOWER_A);
      end else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
         r.val = 6'(c - CHAR_DIGIT_0) + DIGIT_BASE;
      end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         r.val = 6'(c - CHAR_UPPER_A) + UPPER_BASE;
      end else if (c == CHAR_DASH) begin
         r.val = DASH_VALUE;
      end else if (c == CHAR_UNDERSCORE) begin
         r.val = UNDERSCORE_VALUE;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [2:0][7:0] group_bytes(input logic [5:0] s0, input logic [5:0] s1,
                                                   input logic [5:0] s2, input logic [5:0] s3);
      logic [2:0][7:0] b;
      b[0] = {s0, s1[5:4]};
      b[1] = {s1[3:0], s2[5:2]};
      b[2] = {s2[1:0], s3};
      return b;
   endfunction

endpackage

@@ hdl/uabd_front.sv @@
module uabd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_ch,
   input  logic              req_string_end,
   input  logic              accept,
   output uabd_pkg::job_type job,
   output logic              job_valid
);

   logic [5:0]           store_ff [3];
   logic [5:0]           store_in [3];
   logic [5:0]           upd_store [3];
   logic [1:0]           gc_ff;
   logic [1:0]           gc_in;
   logic [1:0]           upd_gc;
   logic                 halted_ff;
   logic                 halted_in;
   uabd_pkg::sextet_type lk;
   logic [2:0][7:0]      grp;
   logic [2:0][7:0]      flush;

   assign lk = uabd_pkg::sextet_of(req_ch);
   assign grp = uabd_pkg::group_bytes(store_ff[0], store_ff[1], store_ff[2], lk.val);
   assign flush = uabd_pkg::group_bytes(upd_store[0], upd_store[1], upd_store[2], 6'd0);

   always_comb begin
      upd_store = store_ff;
      upd_gc = gc_ff;
      halted_in = halted_ff;
      job = '0;
      job_valid = 1'b0;
      if (!halted_ff) begin
         if (lk.ok) begin
            if (gc_ff == uabd_pkg::GROUP_FULL) begin
               job.data = grp;
               job.last_idx = 2'd2;
               job.has_byte = 1'b1;
               job_valid = 1'b1;
               upd_gc = 2'd0;
            end else begin
               upd_store[gc_ff] = lk.val;
               upd_gc = gc_ff + 2'd1;
            end
         end else begin
            halted_in = 1'b1;
         end
      end
      store_in = upd_store;
      gc_in = upd_gc;
      if (req_string_end) begin
         job.message_end = 1'b1;
         if (!job_valid) begin
            job_valid = 1'b1;
            if (upd_gc >= 2'd2) begin
               job.data = flush;
               job.has_byte = 1'b1;
               job.last_idx = (upd_gc == uabd_pkg::GROUP_FULL) ? 2'd1 : 2'd0;
            end
         end
         store_in = '{default: '0};
         gc_in = 2'd0;
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '{default: '0};
         gc_ff <= 2'd0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         store_ff <= store_in;
         gc_ff <= gc_in;
         halted_ff <= halted_in;
      end
   end

endmodule

@@ hdl/uabd_queue.sv @@
module uabd_queue #(
   parameter int DEPTH = uabd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  uabd_pkg::job_type wr_job,
   input  logic              rd_en,
   output uabd_pkg::job_type rd_job,
   output logic              not_empty,
   output logic              full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   uabd_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_wr;
   logic              do_rd;

   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && not_empty;
   assign rd_job = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full = (count_ff == CNT_FULL);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

@@ hdl/uabd_back.sv @@
`include "url_alphabet_base64_decoder_assert.svh"

module uabd_back (
   input  logic              clock,
   input  logic              reset,
   input  uabd_pkg::job_type q_job,
   input  logic              q_not_empty,
   output logic              q_pop,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_has_byte,
   output logic              rsp_run_last,
   output logic              rsp_message_end,
   output logic              empty,
   input  logic              pop
);

   uabd_pkg::job_type cur_ff;
   uabd_pkg::job_type cur_in;
   logic              cur_valid_ff;
   logic              cur_valid_in;
   logic [1:0]        idx_ff;
   logic [1:0]        idx_in;
   logic              taken;
   logic              at_last;

   assign at_last = (idx_ff == cur_ff.last_idx);
   assign taken = pop && cur_valid_ff;
   assign q_pop = q_not_empty && (!cur_valid_ff || (taken && at_last));

   assign empty = !cur_valid_ff;
   assign rsp_data_byte = cur_ff.data[idx_ff];
   assign rsp_has_byte = cur_ff.has_byte;
   assign rsp_run_last = at_last;
   assign rsp_message_end = cur_ff.message_end && at_last;

   always_comb begin
      cur_in = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in = idx_ff;
      if (q_pop) begin
         cur_in = q_job;
         cur_valid_in = 1'b1;
         idx_in = 2'd0;
      end else if (taken) begin
         if (at_last) begin
            cur_valid_in = 1'b0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `UABD_ASSERT_IMPL(a_end_on_last, clock, reset, !empty && rsp_message_end, rsp_run_last)
   `UABD_ASSERT_IMPL(a_marker_ends, clock, reset, !empty && !rsp_has_byte, rsp_message_end && (rsp_data_byte == 8'd0))
   `UABD_ASSERT_NEVER(a_idx_range, clock, reset, cur_valid_ff && (idx_ff > cur_ff.last_idx))
   `UABD_ASSERT_NEXT(a_burst_holds, clock, reset, pop && !empty && !rsp_run_last, !empty)

endmodule

@@ hdl/url_alphabet_base64_decoder.sv @@
// Each job passes through the job queue and then the serialiser's job register.
// One input word per cycle while the queue is not full; one result word per cycle
// while pop is high; a word completing a three-byte group yields a burst of three.
// A four-entry job queue between classifier and serialiser absorbs those bursts.
// Reset: synchronous, active high; clears the held group, count, halt flag, queue and serialiser.
module url_alphabet_base64_decoder #(
   parameter int QUEUE_DEPTH = uabd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_ch,
   input  logic       req_string_end,
   input  logic       push,
   output logic       full,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_byte,
   output logic       rsp_run_last,
   output logic       rsp_message_end,
   output logic       empty,
   input  logic       pop
);

   uabd_pkg::job_type front_job;
   uabd_pkg::job_type q_job;
   logic              front_valid;
   logic              accept;
   logic              q_not_empty;
   logic              q_pop;

   assign accept = push && !full;

   uabd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .req_string_end (req_string_end),
      .accept         (accept),
      .job            (front_job),
      .job_valid      (front_valid)
   );

   uabd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept && front_valid),
      .wr_job    (front_job),
      .rd_en     (q_pop),
      .rd_job    (q_job),
      .not_empty (q_not_empty),
      .full      (full)
   );

   uabd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_job           (q_job),
      .q_not_empty     (q_not_empty),
      .q_pop           (q_pop),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end),
      .empty           (empty),
      .pop             (pop)
   );

endmodule

@@ test/base64_word_checker.sv @@
module base64_word_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_ch,
   input  logic       req_string_end,
   input  logic       push,
   input  logic       full,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_has_byte,
   input  logic       rsp_run_last,
   input  logic       rsp_message_end,
   input  logic       empty,
   input  logic       pop,
   output int         failures,
   output int         pending
);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       run_last;
      logic       message_end;
   } decoded_word_type;

   decoded_word_type expected_words[$];

   logic [5:0] held_sextet[3];
   logic [1:0] held_count;
   logic       halted;

   function automatic uabd_pkg::sextet_type alphabet_index(input logic [7:0] c);
      uabd_pkg::sextet_type s;
      s.ok = 1'b1;
      s.val = '0;
      if (c >= uabd_pkg::CHAR_LOWER_A && c <= uabd_pkg::CHAR_LOWER_Z) begin
         s.val = 6'(c - uabd_pkg::CHAR_LOWER_A);
      end else if (c >= uabd_pkg::CHAR_DIGIT_0 && c <= uabd_pkg::CHAR_DIGIT_9) begin
         s.val = 6'(c - uabd_pkg::CHAR_DIGIT_0 + uabd_pkg::DIGIT_BASE);
      end else if (c >= uabd_pkg::CHAR_UPPER_A && c <= uabd_pkg::CHAR_UPPER_Z) begin
         s.val = 6'(c - uabd_pkg::CHAR_UPPER_A + uabd_pkg::UPPER_BASE);
      end else if (c == uabd_pkg::CHAR_DASH) begin
         s.val = uabd_pkg::DASH_VALUE;
      end else if (c == uabd_pkg::CHAR_UNDERSCORE) begin
         s.val = uabd_pkg::UNDERSCORE_VALUE;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

   function automatic decoded_word_type byte_word(input logic [7:0] b, input logic has);
      decoded_word_type w;
      w = '0;
      w.data_byte = has ? b : 8'h00;
      w.has_byte = has;
      return w;
   endfunction

   task automatic decode_char(input logic [7:0] c, input logic string_end);
      uabd_pkg::sextet_type s;
      decoded_word_type     produced[$];
      int                   last;
      s = alphabet_index(c);
      if (!halted) begin
         if (s.ok) begin
            if (held_count == uabd_pkg::GROUP_FULL) begin
               produced.push_back(byte_word({held_sextet[0], held_sextet[1][5:4]}, 1'b1));
               produced.push_back(byte_word({held_sextet[1][3:0], held_sextet[2][5:2]}, 1'b1));
               produced.push_back(byte_word({held_sextet[2][1:0], s.val}, 1'b1));
               held_count = 2'd0;
            end else begin
               held_sextet[held_count] = s.val;
               held_count = held_count + 2'd1;
            end
         end else begin
            halted = 1'b1;
         end
      end
      if (string_end) begin
         if (held_count >= 2'd2)
            produced.push_back(byte_word({held_sextet[0], held_sextet[1][5:4]}, 1'b1));
         if (held_count == uabd_pkg::GROUP_FULL)
            produced.push_back(byte_word({held_sextet[1][3:0], held_sextet[2][5:2]}, 1'b1));
         if (produced.size() == 0)
            produced.push_back(byte_word(8'h00, 1'b0));
         last = produced.size() - 1;
         produced[last].message_end = 1'b1;
         held_sextet = '{default: '0};
         held_count = 2'd0;
         halted = 1'b0;
      end
      if (produced.size() > 0) begin
         last = produced.size() - 1;
         produced[last].run_last = 1'b1;
      end
      foreach (produced[i])
         expected_words.push_back(produced[i]);
   endtask

   task automatic check_field(input string field, input logic [7:0] exp, input logic [7:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp, act);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      decoded_word_type exp;
      if (reset) begin
         held_sextet = '{default: '0};
         held_count = 2'd0;
         halted = 1'b0;
         expected_words.delete();
         failures = 0;
      end else begin
         if (push && !full)
            decode_char(req_ch, req_string_end);
         if (pop && !empty) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none actual %h/%b/%b/%b", $time,
                        rsp_data_byte, rsp_has_byte, rsp_run_last, rsp_message_end);
               failures++;
            end else begin
               exp = expected_words.pop_front();
               check_field("data_byte", exp.data_byte, rsp_data_byte);
               check_field("has_byte", 8'(exp.has_byte), 8'(rsp_has_byte));
               check_field("run_last", 8'(exp.run_last), 8'(rsp_run_last));
               check_field("message_end", 8'(exp.message_end), 8'(rsp_message_end));
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

@@ test/testbench.sv @@
module testbench;

   localparam int         CYCLE_LIMIT = 40000;
   localparam int         RANDOM_WORDS = 80;
   localparam int         SQUEEZE_CYCLES = 60;
   localparam logic [7:0] PAD_CHAR = 8'h3d;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic [7:0] req_ch = 8'h00;
   logic       req_string_end = 1'b0;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] rsp_data_byte;
   logic       rsp_has_byte;
   logic       rsp_run_last;
   logic       rsp_message_end;
   logic       empty;
   logic       pop = 1'b0;

   int failures;
   int pending;
   int cycles = 0;
   bit calm = 1'b0;
   bit squeeze_start = 1'b0;

   always #5 clock = ~clock;

   url_alphabet_base64_decoder dut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch), .req_string_end(req_string_end), .push(push), .full(full),
      .rsp_data_byte(rsp_data_byte), .rsp_has_byte(rsp_has_byte),
      .rsp_run_last(rsp_run_last), .rsp_message_end(rsp_message_end),
      .empty(empty), .pop(pop)
   );

   base64_word_checker checker_i (
      .clock(clock), .reset(reset),
      .req_ch(req_ch), .req_string_end(req_string_end), .push(push), .full(full),
      .rsp_data_byte(rsp_data_byte), .rsp_has_byte(rsp_has_byte),
      .rsp_run_last(rsp_run_last), .rsp_message_end(rsp_message_end),
      .empty(empty), .pop(pop),
      .failures(failures), .pending(pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // hold off the result side once for a long stretch, otherwise pop at random, or always while calm
   always @(posedge clock) begin
      int  hold_left;
      bit  squeeze_done;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (squeeze_start && !squeeze_done) begin
            hold_left = SQUEEZE_CYCLES;
            squeeze_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= calm || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   function automatic logic [7:0] alphabet_char(input int unsigned idx);
      if (idx < 26)
         return uabd_pkg::CHAR_LOWER_A + 8'(idx);
      else if (idx < 36)
         return uabd_pkg::CHAR_DIGIT_0 + 8'(idx - 26);
      else if (idx < 62)
         return uabd_pkg::CHAR_UPPER_A + 8'(idx - 36);
      else if (idx == 62)
         return uabd_pkg::CHAR_DASH;
      return uabd_pkg::CHAR_UNDERSCORE;
   endfunction

   task automatic send_word(input logic [7:0] c, input logic string_end);
      while (!calm && $urandom_range(0, 99) < 11) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_ch <= c;
      req_string_end <= string_end;
      do @(posedge clock); while (full);
   endtask

   initial begin
      int sent;
      int len;
      int pads;
      logic [7:0] c;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full group closing the string
      send_word("a", 1'b0); send_word("z", 1'b0); send_word("0", 1'b0); send_word("9", 1'b1);
      // three held values at the end
      send_word("A", 1'b0); send_word("Z", 1'b0); send_word("-", 1'b1);
      // halt on the last character with one value held
      send_word("_", 1'b0); send_word(8'hff, 1'b1);
      // halt on pad, later characters ignored
      send_word("b", 1'b0); send_word("c", 1'b0); send_word(PAD_CHAR, 1'b0);
      send_word("d", 1'b0); send_word(8'h00, 1'b1);
      // strings that end without a byte
      send_word(PAD_CHAR, 1'b1);
      send_word("Q", 1'b1);
      // full group mid-string, then a lone value at the end
      send_word("_", 1'b0); send_word("_", 1'b0); send_word("_", 1'b0); send_word("_", 1'b0);
      send_word("-", 1'b1);
      // characters just outside the alphabet ranges
      send_word(8'h60, 1'b0); send_word(8'h7b, 1'b1);
      send_word(8'h2f, 1'b1); send_word(8'h5b, 1'b1);

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         calm = (sent >= 20 && sent < 40);
         if (sent >= 55 && !squeeze_start)
            squeeze_start = 1'b1;
         if ($urandom_range(0, 99) < 80) begin
            len = $urandom_range(1, 10);
            pads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            for (int i = 0; i < len; i++) begin
               c = alphabet_char($urandom_range(0, 63));
               if ($urandom_range(0, 24) == 0)
                  c = 8'($urandom_range(0, 255));
               send_word(c, (i == len - 1) && (pads == 0));
               sent++;
            end
            for (int i = 0; i < pads; i++)
               send_word(PAD_CHAR, i == pads - 1);
         end else begin
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            sent++;
         end
      end
      calm = 1'b0;
      // close any string left open
      send_word(alphabet_char($urandom_range(0, 63)), 1'b1);
      push <= 1'b0;

      repeat (2) @(posedge clock);
      wait (pending == 0);
      repeat (10) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ url_alphabet_base64_decoder.f @@
+incdir+hdl
hdl/uabd_pkg.sv
hdl/uabd_front.sv
hdl/uabd_queue.sv
hdl/uabd_back.sv
hdl/url_alphabet_base64_decoder.sv
test/base64_word_checker.sv
test/testbench.sv
